FILE: rtl/core/rgbc_pkg.sv
// shared types, constants and helpers for the rgb 3x3 convolution block
package rgbc_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_ROWS  = 4096;
    localparam int COEF_BITS = 12;
    localparam int LINE_AW   = $clog2(MAX_WIDTH);
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int KROW_BITS = 3 * COEF_BITS;
    localparam int PROD_BITS = COEF_BITS + 9;
    localparam int SUM_BITS  = PROD_BITS + 4;

    // result kinds of one input, in emission order
    localparam int EM_UP_MID    = 0;
    localparam int EM_UP_EDGE   = 1;
    localparam int EM_LAST_MID  = 2;
    localparam int EM_LAST_EDGE = 3;

    typedef enum logic [2:0] {
        REG_KERNEL_TOP = 3'd0,
        REG_KERNEL_MID = 3'd1,
        REG_KERNEL_BOT = 3'd2,
        REG_WIDTH      = 3'd3,
        REG_HEIGHT     = 3'd4
    } reg_idx_t;

    typedef logic [23:0] pixel_t;

    typedef struct packed {
        logic [KROW_BITS-1:0] k_top;
        logic [KROW_BITS-1:0] k_mid;
        logic [KROW_BITS-1:0] k_bot;
        logic [10:0]          width;
        logic [12:0]          height;
    } cfg_t;

    typedef struct packed {
        pixel_t      top;
        pixel_t      mid;
        pixel_t      pix;
        logic [9:0]  col;
        logic [11:0] row;
        logic [3:0]  mask;
    } entry_t;

    function automatic logic [7:0] clamp_sum(input logic signed [SUM_BITS-1:0] s);
        logic [7:0] v;
        if (s <= 0) begin
            v = 8'd0;
        end else if (|s[SUM_BITS-2:16]) begin
            v = 8'd255;
        end else begin
            v = s[15:8];
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/rgbc_ram.sv
// generic single-write, single-read ram with registered read data
module rgbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/rgbc_front.sv
// front end: pixel intake, position counters, line stores and result classification
module rgbc_front import rgbc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  logic [23:0] s_tdata,
    output logic   q_push,
    output entry_t q_entry,
    input  logic   q_full
);

    logic [9:0]  col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic        s1_valid_reg, s1_valid_next;
    pixel_t      s1_pix_reg;
    logic [9:0]  s1_col_reg;
    logic [11:0] s1_row_reg;
    logic [3:0]  s1_mask_reg;
    logic        s1_stale_reg;
    pixel_t      fwd_old_reg, fwd_new_reg;

    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic        end_row, last_row, accept, adv;
    logic [3:0]  mask;
    pixel_t      old_rd, new_rd, old_eff, new_eff, old_wr;

    always_comb begin
        if (cfg.width == 11'd0) begin
            w_eff = 11'd1;
        end else if (cfg.width > 11'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = cfg.width;
        end
        if (cfg.height == 13'd0) begin
            h_eff = 13'd1;
        end else if (cfg.height > 13'(MAX_ROWS)) begin
            h_eff = 13'(MAX_ROWS);
        end else begin
            h_eff = cfg.height;
        end
    end

    assign end_row  = {1'b0, col_reg} >= (w_eff - 11'd1);
    assign last_row = {1'b0, row_reg} >= (h_eff - 13'd1);

    always_comb begin
        mask = '0;
        mask[EM_UP_MID]    = (row_reg != '0) && (col_reg != '0);
        mask[EM_UP_EDGE]   = (row_reg != '0) && end_row;
        mask[EM_LAST_MID]  = last_row && (col_reg != '0);
        mask[EM_LAST_EDGE] = last_row && end_row;
    end

    assign adv      = s1_valid_reg && !q_full;
    assign s_tready = !s1_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (end_row) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 12'd1;
            end else begin
                col_next = col_reg + 10'd1;
            end
        end
        s1_valid_next = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // a read in the same beat as the previous pixel's write sees old data: forward it
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg   <= s_tdata;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_mask_reg  <= mask;
            s1_stale_reg <= s1_valid_reg && (s1_col_reg == col_reg);
            fwd_old_reg  <= old_wr;
            fwd_new_reg  <= s1_pix_reg;
        end
    end

    rgbc_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older (
        .aclk (aclk),
        .we   (adv),
        .waddr(s1_col_reg[LINE_AW-1:0]),
        .wdata(old_wr),
        .re   (accept),
        .raddr(col_reg[LINE_AW-1:0]),
        .rdata(old_rd)
    );

    rgbc_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer (
        .aclk (aclk),
        .we   (adv),
        .waddr(s1_col_reg[LINE_AW-1:0]),
        .wdata(s1_pix_reg),
        .re   (accept),
        .raddr(col_reg[LINE_AW-1:0]),
        .rdata(new_rd)
    );

    assign old_eff = s1_stale_reg ? fwd_old_reg : old_rd;
    assign new_eff = s1_stale_reg ? fwd_new_reg : new_rd;
    assign old_wr  = (s1_row_reg == '0) ? s1_pix_reg : new_eff;

    assign q_push = adv;

    always_comb begin
        q_entry.top  = (s1_row_reg == '0) ? s1_pix_reg : old_eff;
        q_entry.mid  = (s1_row_reg == '0) ? s1_pix_reg : new_eff;
        q_entry.pix  = s1_pix_reg;
        q_entry.col  = s1_col_reg;
        q_entry.row  = s1_row_reg;
        q_entry.mask = s1_mask_reg;
    end

endmodule

FILE: rtl/core/rgbc_queue.sv
// short fifo between the front end and the filter back end
module rgbc_queue import rgbc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   head_valid
);

    entry_t          slots [QDEPTH];
    logic [QAW-1:0]  wptr_reg, rptr_reg;
    logic [QAW:0]    count_reg, count_next;

    assign full       = count_reg == (QAW+1)'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slots[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn) full |-> !push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn) !head_valid |-> !pop)
        else $error("queue pop while empty");

endmodule

FILE: rtl/core/rgbc_back.sv
// back end: 3x3 window, result sequencing and the convolution pipeline
module rgbc_back import rgbc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  entry_t head,
    input  logic   head_valid,
    output logic   pop,
    output logic   m_tvalid,
    input  logic   m_tready,
    output logic [47:0] m_tdata,
    output logic   m_tlast,
    output logic   m_tuser
);

    entry_t     cur_reg;
    logic       cur_valid_reg;
    logic [3:0] rem_reg;
    pixel_t     win_reg [9];

    logic       en, issue, issue_last, done, rows_last, cols_edge;
    logic [3:0] pick;
    pixel_t     vin [3];

    // pipeline registers
    logic       p1_valid_reg, p2_valid_reg, p3_valid_reg, o_valid_reg;
    pixel_t     p1_pix_reg [9];
    logic [21:0] p1_tag_reg, p2_tag_reg, p3_tag_reg, o_tag_reg;
    logic [1:0] p1_flag_reg, p2_flag_reg, p3_flag_reg, o_flag_reg;
    logic signed [PROD_BITS-1:0] p2_prod_reg [3][9];
    logic signed [SUM_BITS-1:0]  p3_sum_reg [3];
    logic [7:0] o_ch_reg [3];

    logic signed [PROD_BITS-1:0] prod [3][9];
    logic signed [SUM_BITS-1:0]  sum [3];
    logic signed [COEF_BITS-1:0] coef [9];
    logic [KROW_BITS-1:0]        krow [3];
    logic [21:0] tag;
    logic [1:0]  rsel [3];
    logic [1:0]  csel [3];

    assign en         = !o_valid_reg || m_tready;
    assign pick       = rem_reg & (~rem_reg + 4'd1);
    assign issue      = cur_valid_reg && (rem_reg != '0) && en;
    assign issue_last = (rem_reg & ~pick) == '0;
    assign done       = !cur_valid_reg || (rem_reg == '0) || (issue && issue_last);
    assign pop        = done && head_valid;
    assign rows_last  = pick[EM_LAST_MID] || pick[EM_LAST_EDGE];
    assign cols_edge  = pick[EM_UP_EDGE] || pick[EM_LAST_EDGE];

    assign vin[0] = head.top;
    assign vin[1] = head.mid;
    assign vin[2] = head.pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end else if (pop) begin
            cur_valid_reg <= 1'b1;
            rem_reg       <= head.mask;
        end else begin
            if (done) begin
                cur_valid_reg <= 1'b0;
            end
            if (issue) begin
                rem_reg <= rem_reg & ~pick;
            end
        end
    end

    // window shifts once per input, when its entry leaves the queue
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
            for (int k = 0; k < 3; k++) begin
                if (head.col == '0) begin
                    win_reg[k*3]   <= vin[k];
                    win_reg[k*3+1] <= vin[k];
                end else begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[k*3+2] <= vin[k];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rsel[i] = rows_last ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
            csel[i] = cols_edge ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
        end
        tag[9:0]   = cols_edge ? cur_reg.col : cur_reg.col - 10'd1;
        tag[21:10] = rows_last ? cur_reg.row : cur_reg.row - 12'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            o_valid_reg  <= p3_valid_reg;
        end
    end

    assign krow[0] = cfg.k_top;
    assign krow[1] = cfg.k_mid;
    assign krow[2] = cfg.k_bot;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            coef[i] = krow[i/3][(i%3)*COEF_BITS +: COEF_BITS];
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 9; i++) begin
                prod[ch][i] = PROD_BITS'(coef[i] * $signed({1'b0, p1_pix_reg[i][ch*8 +: 8]}));
            end
            sum[ch] = '0;
            for (int i = 0; i < 9; i++) begin
                sum[ch] = sum[ch] + SUM_BITS'(p2_prod_reg[ch][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                p1_pix_reg[i] <= win_reg[4'(rsel[i/3]) * 4'd3 + 4'(csel[i%3])];
            end
            p1_tag_reg  <= tag;
            p1_flag_reg <= {pick[EM_LAST_EDGE], issue_last};
            p2_prod_reg <= prod;
            p2_tag_reg  <= p1_tag_reg;
            p2_flag_reg <= p1_flag_reg;
            p3_sum_reg  <= sum;
            p3_tag_reg  <= p2_tag_reg;
            p3_flag_reg <= p2_flag_reg;
            for (int ch = 0; ch < 3; ch++) begin
                o_ch_reg[ch] <= clamp_sum(p3_sum_reg[ch]);
            end
            o_tag_reg  <= p3_tag_reg;
            o_flag_reg <= p3_flag_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {2'b00, o_tag_reg, o_ch_reg[2], o_ch_reg[1], o_ch_reg[0]};
    assign m_tlast  = o_flag_reg[0];
    assign m_tuser  = o_flag_reg[1];

    a_frame_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without end of run");
    a_issue_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> cur_valid_reg && $onehot(pick))
        else $error("issue without a current entry");
    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(o_tag_reg) && o_valid_reg)
        else $error("output changed while stalled");

endmodule

FILE: rtl/core/rgb_conv3x3_clamp_edge.sv
// top level: config registers and the front end, queue and back end of the 3x3 filter
//
// rgb pixels arrive in raster order on s_tdata (red, green, blue from bit 0 up)
// and are taken on each beat where s_tvalid and s_tready are high. filtered
// pixels leave on m_tdata tagged with their column and row; m_tlast marks the
// last result of one input pixel and m_tuser the result of the frame's final
// pixel. results lag one row and one pixel; during the final row its own
// results interleave with those of the row above.
// kernel rows, width and height are written through cfg_valid/cfg_index/cfg_data
// (always ready) while the block is idle, a rule on the user that the block does
// not enforce; reset loads the identity kernel and a 1024 x 1024 frame.
// throughput: one pixel per cycle unless backpressured; the back end issues the
// results of an input (up to 4) one after another, so row ends and the last row
// apply brief backpressure through a four-entry queue. a stalled receiver
// freezes the filter pipeline; the queue and then s_tready absorb it. reset
// (aresetn, low, synchronous) clears counters and the queue; line stores are
// not cleared.
module rgb_conv3x3_clamp_edge import rgbc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [35:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red, green, blue, out_column, out_row, zero pad
    output logic        m_tlast,
    output logic        m_tuser    // frame_done
);

    cfg_t   cfg_reg;
    entry_t q_in, q_head;
    logic   q_push, q_full, q_pop, q_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.k_top  <= '0;
            cfg_reg.k_mid  <= KROW_BITS'(256) << COEF_BITS;
            cfg_reg.k_bot  <= '0;
            cfg_reg.width  <= 11'd1024;
            cfg_reg.height <= 13'd1024;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_KERNEL_TOP: cfg_reg.k_top  <= cfg_data[KROW_BITS-1:0];
                REG_KERNEL_MID: cfg_reg.k_mid  <= cfg_data[KROW_BITS-1:0];
                REG_KERNEL_BOT: cfg_reg.k_bot  <= cfg_data[KROW_BITS-1:0];
                REG_WIDTH:      cfg_reg.width  <= cfg_data[10:0];
                REG_HEIGHT:     cfg_reg.height <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    rgbc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .q_push  (q_push),
        .q_entry (q_in),
        .q_full  (q_full)
    );

    rgbc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .head_valid(q_valid)
    );

    rgbc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .head      (q_head),
        .head_valid(q_valid),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
